FILE: hw/rtl/clss_pkg.sv
// shared constants, widths and helpers for the capacity limited slot store
`timescale 1ns / 1ps
package clss_pkg;

   localparam int MAX_SLOTS  = 16;
   localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);
   localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int KEY_W      = 32;
   localparam int AMOUNT_W   = 31;
   localparam int FIX_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_STEPS  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MASS_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE = 2'd2;

   localparam logic CMD_PACK   = 1'b0;
   localparam logic CMD_UNPACK = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_BAD_KEY = 1'b1;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   // clamp a wide product into the signed 32-bit range
   function automatic logic [FIX_W-1:0] sat32(input logic signed [63:0] p);
      logic [FIX_W-1:0] r;
      if (p > SAT_MAX) begin
         r = 32'h7FFF_FFFF;
      end else if (p < SAT_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = p[FIX_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/capacity_limited_slot_store.sv
// capacity limited slot store: slot table, capacity totals and request sequencer
`timescale 1ns / 1ps
// Holds up to 16 slots of (item key, amount) plus running signed Q16.16 mass and
// volume totals. A pack word adds as many units as the request, the remaining mass
// over the unit mass and the remaining volume over the unit volume allow (a unit
// cost of zero or below sets no bound); units go to the slot holding the key, else
// the first free slot. slots_in_use of zero is bulk mode with one key in slot 0.
// An unpack word removes up to the held amount, frees an emptied slot and lowers
// the totals, clamping at zero. One word is handled at a time and req_stall stays
// high until its result has been taken. A word with key zero or amount zero goes
// straight to the response. Otherwise the slot scan visits each active slot (only
// slot 0 in bulk mode), each capacity bound that needs a quotient is set up, runs
// 32 restoring divider steps and takes the quotient, and the two total updates
// share one 32x32 multiplier; the response then waits on rsp_stall.
module capacity_limited_slot_store (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [clss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [clss_pkg::FIX_W-1:0]       csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [clss_pkg::KEY_W-1:0]       req_item_key,
   input  logic [clss_pkg::AMOUNT_W-1:0]    req_amount,
   input  logic signed [clss_pkg::FIX_W-1:0] req_mass_each,
   input  logic signed [clss_pkg::FIX_W-1:0] req_volume_each,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [clss_pkg::AMOUNT_W-1:0]    rsp_moved_amount,
   output logic                             rsp_status
);
   import clss_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_SEL, ST_BOUND, ST_DIV, ST_QUOT, ST_CHK, ST_UNPK,
      ST_PACK_WR, ST_MUL_M, ST_MUL_V, ST_FIN, ST_RESP
   } state_type;

   state_type state_ff;

   // configuration
   logic [FIX_W-1:0]      mass_limit_ff;
   logic [FIX_W-1:0]      volume_limit_ff;
   logic [SLOT_CNT_W-1:0] slots_in_use_ff;

   // slot table and totals
   logic [KEY_W-1:0] slot_item_ff   [MAX_SLOTS];
   logic [FIX_W-1:0] slot_amount_ff [MAX_SLOTS];
   logic [FIX_W-1:0] mass_used_ff;
   logic [FIX_W-1:0] volume_used_ff;

   // latched request word
   logic                     cmd_ff;
   logic [KEY_W-1:0]         key_ff;
   logic [AMOUNT_W-1:0]      amount_ff;
   logic signed [FIX_W-1:0]  umass_ff;
   logic signed [FIX_W-1:0]  uvol_ff;

   // scan results
   logic [SLOT_CNT_W-1:0] cnt_ff;
   logic                  match_ff;
   logic [SLOT_IDX_W-1:0] match_idx_ff;
   logic                  free_ff;
   logic [SLOT_IDX_W-1:0] free_idx_ff;
   logic                  have_ff;
   logic [SLOT_IDX_W-1:0] slot_ff;

   // bound, divider and multiplier
   logic                     phase_ff;   // 0 mass bound, 1 volume bound
   logic [AMOUNT_W-1:0]      fit_ff;
   logic [FIX_W-1:0]         rem_ff;
   logic [FIX_W-1:0]         dvd_ff;
   logic [FIX_W-1:0]         div_ff;
   logic signed [63:0]       prod_ff;

   // response registers
   logic                rsp_valid_ff;
   logic [AMOUNT_W-1:0] rsp_moved_ff;
   logic                rsp_status_ff;

   // derived values
   logic [SLOT_CNT_W-1:0]   n_active;
   logic [SLOT_IDX_W-1:0]   scan_idx;
   logic [KEY_W-1:0]        scan_item;
   logic                    scan_last;
   logic signed [FIX_W-1:0] bound_cost;
   logic signed [FIX_W-1:0] bound_room;
   logic [FIX_W-1:0]        trial;
   logic                    trial_ge;
   logic [FIX_W-1:0]        slot_amt;
   logic [AMOUNT_W-1:0]     unpk_moved;
   logic signed [FIX_W-1:0] mul_a;
   logic signed [63:0]      mul_p;
   logic [FIX_W-1:0]        prod_sat;

   // more slots than the table holds act as a full table
   assign n_active  = (slots_in_use_ff > SLOT_CNT_W'(MAX_SLOTS)) ?
                      SLOT_CNT_W'(MAX_SLOTS) : slots_in_use_ff;
   assign scan_idx  = cnt_ff[SLOT_IDX_W-1:0];
   assign scan_item = slot_item_ff[scan_idx];
   assign scan_last = ((cnt_ff + SLOT_CNT_W'(1)) == n_active);

   // remaining room wraps to signed 32 bits
   assign bound_cost = phase_ff ? uvol_ff : umass_ff;
   assign bound_room = phase_ff ? signed'(volume_limit_ff - volume_used_ff)
                                : signed'(mass_limit_ff - mass_used_ff);

   // restoring divider step, remainder stays below the divisor
   assign trial    = {rem_ff[FIX_W-2:0], dvd_ff[FIX_W-1]};
   assign trial_ge = (trial >= div_ff);

   assign slot_amt   = slot_amount_ff[slot_ff];
   assign unpk_moved = ({1'b0, amount_ff} < slot_amt) ? amount_ff : slot_amt[AMOUNT_W-1:0];

   // shared multiplier: unit cost times moved units
   assign mul_a    = (state_ff == ST_MUL_M) ? umass_ff : uvol_ff;
   assign mul_p    = 64'(mul_a) * 64'(signed'({1'b0, fit_ff}));
   assign prod_sat = sat32(prod_ff);

   // total update: wraps on pack, wraps then clamps at zero on unpack
   function automatic logic [FIX_W-1:0] next_total(input logic [FIX_W-1:0] used,
                                                    input logic [FIX_W-1:0] delta,
                                                    input logic             cmd);
      logic [FIX_W-1:0] d;
      d = used - delta;
      if (cmd == CMD_PACK) begin
         return used + delta;
      end else if (d[FIX_W-1]) begin
         return '0;
      end else begin
         return d;
      end
   endfunction

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_moved_amount = rsp_moved_ff;
   assign rsp_status       = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         mass_limit_ff   <= '0;
         volume_limit_ff <= '0;
         slots_in_use_ff <= '0;
         mass_used_ff    <= '0;
         volume_used_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_item_ff[i]   <= '0;
            slot_amount_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MASS_LIMIT:   mass_limit_ff   <= csr_wr_data;
               CSR_VOLUME_LIMIT: volume_limit_ff <= csr_wr_data;
               CSR_SLOTS_IN_USE: slots_in_use_ff <= csr_wr_data[SLOT_CNT_W-1:0];
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff    <= req_cmd;
                  key_ff    <= req_item_key;
                  amount_ff <= req_amount;
                  umass_ff  <= req_mass_each;
                  uvol_ff   <= req_volume_each;
                  cnt_ff    <= '0;
                  match_ff  <= 1'b0;
                  free_ff   <= 1'b0;
                  rsp_moved_ff  <= '0;
                  rsp_status_ff <= STATUS_OK;
                  if (req_item_key == '0) begin
                     rsp_status_ff <= STATUS_BAD_KEY;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= ST_RESP;
                  end else if (req_amount == '0) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RESP;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end

            ST_SCAN: begin
               if (n_active == '0) begin
                  // bulk mode: slot 0 only
                  match_idx_ff <= '0;
                  match_ff     <= (slot_item_ff[0] == key_ff) ||
                                  ((cmd_ff == CMD_PACK) && (slot_item_ff[0] == '0));
                  state_ff     <= ST_SEL;
               end else begin
                  if (!match_ff && scan_item == key_ff) begin
                     match_ff     <= 1'b1;
                     match_idx_ff <= scan_idx;
                  end
                  if (!free_ff && scan_item == '0) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= scan_idx;
                  end
                  cnt_ff <= cnt_ff + SLOT_CNT_W'(1);
                  if (scan_last) begin
                     state_ff <= ST_SEL;
                  end
               end
            end

            ST_SEL: begin
               slot_ff  <= match_ff ? match_idx_ff : free_idx_ff;
               have_ff  <= match_ff || free_ff;
               fit_ff   <= amount_ff;
               phase_ff <= 1'b0;
               if (cmd_ff == CMD_UNPACK) begin
                  if (match_ff) begin
                     state_ff <= ST_UNPK;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RESP;
                  end
               end else begin
                  state_ff <= ST_BOUND;
               end
            end

            ST_BOUND: begin
               if (bound_cost <= 0) begin
                  // no bound from this cost
                  phase_ff <= 1'b1;
                  if (phase_ff) begin
                     state_ff <= ST_CHK;
                  end
               end else if (bound_room <= 0) begin
                  fit_ff   <= '0;
                  state_ff <= ST_CHK;
               end else begin
                  rem_ff   <= '0;
                  dvd_ff   <= bound_room;
                  div_ff   <= bound_cost;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end

            ST_DIV: begin
               rem_ff <= trial_ge ? (trial - div_ff) : trial;
               dvd_ff <= {dvd_ff[FIX_W-2:0], trial_ge};
               cnt_ff <= cnt_ff + SLOT_CNT_W'(1);
               if (cnt_ff == SLOT_CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_QUOT;
               end
            end

            ST_QUOT: begin
               // dvd_ff now holds the quotient
               if (dvd_ff < {1'b0, fit_ff}) begin
                  fit_ff <= dvd_ff[AMOUNT_W-1:0];
               end
               phase_ff <= 1'b1;
               state_ff <= phase_ff ? ST_CHK : ST_BOUND;
            end

            ST_CHK: begin
               if (fit_ff == '0 || !have_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_RESP;
               end else begin
                  state_ff <= ST_PACK_WR;
               end
            end

            ST_UNPK: begin
               slot_amount_ff[slot_ff] <= slot_amt - {1'b0, unpk_moved};
               if (slot_amt == {1'b0, unpk_moved}) begin
                  slot_item_ff[slot_ff] <= '0;
               end
               fit_ff <= unpk_moved;
               if (unpk_moved == '0) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_RESP;
               end else begin
                  state_ff <= ST_MUL_M;
               end
            end

            ST_PACK_WR: begin
               slot_item_ff[slot_ff]   <= key_ff;
               slot_amount_ff[slot_ff] <= slot_amt + {1'b0, fit_ff};
               state_ff                <= ST_MUL_M;
            end

            ST_MUL_M: begin
               prod_ff  <= mul_p;
               state_ff <= ST_MUL_V;
            end

            ST_MUL_V: begin
               mass_used_ff <= next_total(mass_used_ff, prod_sat, cmd_ff);
               prod_ff      <= mul_p;
               state_ff     <= ST_FIN;
            end

            ST_FIN: begin
               volume_used_ff <= next_total(volume_used_ff, prod_sat, cmd_ff);
               rsp_moved_ff   <= fit_ff;
               rsp_valid_ff   <= 1'b1;
               state_ff       <= ST_RESP;
            end

            ST_RESP: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: tb/sv/capacity_limited_slot_store_tb.sv
// self-checking testbench for the capacity limited slot store
`timescale 1ns / 1ps
module capacity_limited_slot_store_tb;
   import clss_pkg::*;

   // one request word and one response word
   typedef struct {
      logic                     cmd;
      logic [KEY_W-1:0]         key;
      logic [AMOUNT_W-1:0]      amount;
      logic signed [FIX_W-1:0]  mass_each;
      logic signed [FIX_W-1:0]  volume_each;
   } req_word_type;

   typedef struct {
      logic [AMOUNT_W-1:0] moved;
      logic                status;
   } rsp_word_type;

   localparam int IDLE_LIMIT = 6000;  // above the slowest word and the long receiver hold
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_WAIT = 150;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [FIX_W-1:0]        csr_wr_data;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_cmd;
   logic [KEY_W-1:0]        req_item_key;
   logic [AMOUNT_W-1:0]     req_amount;
   logic signed [FIX_W-1:0] req_mass_each;
   logic signed [FIX_W-1:0] req_volume_each;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [AMOUNT_W-1:0]     rsp_moved_amount;
   logic                    rsp_status;

   capacity_limited_slot_store u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_item_key    (req_item_key),
      .req_amount      (req_amount),
      .req_mass_each   (req_mass_each),
      .req_volume_each (req_volume_each),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_moved_amount(rsp_moved_amount),
      .rsp_status      (rsp_status)
   );

   // ---------------------------------------------------------------
   // shadow copy of the container state and its registers
   // ---------------------------------------------------------------
   logic [FIX_W-1:0] shadow_mass_limit;
   logic [FIX_W-1:0] shadow_volume_limit;
   logic [4:0]       shadow_slots;
   logic [KEY_W-1:0] shadow_key[MAX_SLOTS] = '{default: '0};
   logic [31:0]      shadow_amount[MAX_SLOTS] = '{default: '0};
   logic [FIX_W-1:0] shadow_mass_used = '0;
   logic [FIX_W-1:0] shadow_volume_used = '0;

   req_word_type pending_words[$];   // words waiting for the driver
   rsp_word_type expected_rsp[$];    // predicted responses, oldest first
   int        errors = 0;
   int        rsp_seen = 0;
   bit        no_gaps;            // set by the sequencer for gap-free phases

   // unit cost times units, clamped to the signed 32-bit range
   function automatic logic signed [63:0] clamp_cost(logic signed [63:0] cost,
                                                     logic [31:0] units);
      logic signed [63:0] p;
      p = cost * $signed({32'd0, units});
      if (p > SAT_MAX) p = SAT_MAX;
      if (p < SAT_MIN) p = SAT_MIN;
      return p;
   endfunction

   // units that fit in the remaining room; non-positive cost is unbounded
   function automatic logic [31:0] room_units(logic signed [63:0] room,
                                              logic signed [63:0] cost);
      logic signed [63:0] q;
      if (cost <= 0) return 32'hFFFF_FFFF;
      if (room <= 0) return 32'd0;
      q = room / cost;
      return q[31:0];
   endfunction

   // apply one accepted word to the shadow state and give its response
   function automatic rsp_word_type apply_word(req_word_type w);
      rsp_word_type       r;
      int                 n;
      int                 slot;
      logic [FIX_W-1:0]   diff;
      logic signed [63:0] room_m;
      logic signed [63:0] room_v;
      logic signed [63:0] pm;
      logic signed [63:0] pv;
      logic signed [63:0] t;
      logic [31:0]        fit;
      logic [31:0]        bm;
      logic [31:0]        bv;
      logic [31:0]        req;
      logic [31:0]        moved;
      r.moved  = '0;
      r.status = STATUS_OK;
      req      = {1'b0, w.amount};
      n        = (shadow_slots > MAX_SLOTS) ? MAX_SLOTS : shadow_slots;
      slot     = -1;
      moved    = 0;
      if (w.key == 0) begin
         r.status = STATUS_BAD_KEY;
         return r;
      end
      if (req == 0) return r;

      // locate the slot holding this key (bulk mode has only slot 0)
      if (n == 0) begin
         if (shadow_key[0] == w.key || (w.cmd == CMD_PACK && shadow_key[0] == 0))
            slot = 0;
      end else begin
         for (int i = 0; i < n; i++) begin
            if (slot < 0 && shadow_key[i] == w.key) slot = i;
         end
      end

      if (w.cmd == CMD_PACK) begin
         diff   = shadow_mass_limit - shadow_mass_used;
         room_m = $signed(diff);
         diff   = shadow_volume_limit - shadow_volume_used;
         room_v = $signed(diff);
         bm     = room_units(room_m, w.mass_each);
         bv     = room_units(room_v, w.volume_each);
         fit    = req;
         if (bm < fit) fit = bm;
         if (bv < fit) fit = bv;
         if (fit == 0) return r;
         if (slot < 0 && n != 0) begin
            for (int i = 0; i < n; i++) begin
               if (slot < 0 && shadow_key[i] == 0) begin
                  slot = i;
                  shadow_amount[i] = 0;
               end
            end
         end
         if (slot < 0) return r;
         shadow_key[slot]    = w.key;
         shadow_amount[slot] = shadow_amount[slot] + fit;
         pm = clamp_cost(w.mass_each, fit);
         pv = clamp_cost(w.volume_each, fit);
         shadow_mass_used   = shadow_mass_used + pm[31:0];
         shadow_volume_used = shadow_volume_used + pv[31:0];
         moved = fit;
      end else begin
         if (slot < 0) return r;
         moved = (req < shadow_amount[slot]) ? req : shadow_amount[slot];
         shadow_amount[slot] = shadow_amount[slot] - moved;
         if (shadow_amount[slot] == 0) shadow_key[slot] = 0;
         if (moved > 0) begin
            // totals clamp at zero after the wrapping subtract
            pm   = clamp_cost(w.mass_each, moved);
            diff = shadow_mass_used - pm[31:0];
            t    = $signed(diff);
            shadow_mass_used = (t < 0) ? '0 : diff;
            pv   = clamp_cost(w.volume_each, moved);
            diff = shadow_volume_used - pv[31:0];
            t    = $signed(diff);
            shadow_volume_used = (t < 0) ? '0 : diff;
         end
      end
      r.moved = moved[AMOUNT_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // clock and reset
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // driver: bursts of words separated by random gaps
   // ---------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid       <= 1'b0;
         req_cmd         <= CMD_PACK;
         req_item_key    <= '0;
         req_amount      <= '0;
         req_mass_each   <= '0;
         req_volume_each <= '0;
         burst_left      <= 0;
         gap_left        <= 0;
      end else if (!req_valid || !req_stall) begin
         // word accepted at this edge: predict it from the port values
         if (req_valid) begin
            req_word_type w;
            w.cmd         = req_cmd;
            w.key         = req_item_key;
            w.amount      = req_amount;
            w.mass_each   = req_mass_each;
            w.volume_each = req_volume_each;
            expected_rsp.push_back(apply_word(w));
         end
         if (gap_left > 0 && !no_gaps) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_word_type nw;
            nw = pending_words.pop_front();
            req_valid       <= 1'b1;
            req_cmd         <= nw.cmd;
            req_item_key    <= nw.key;
            req_amount      <= nw.amount;
            req_mass_each   <= nw.mass_each;
            req_volume_each <= nw.volume_each;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver stall: a stall pattern redrawn periodically, plus one
   // long hold after 150 responses so the block backs up its input
   // ---------------------------------------------------------------
   int  stall_mode;
   int  mode_cnt;
   int  hold_cnt;
   bit  hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 0;
         mode_cnt   <= 0;
         hold_cnt   <= 0;
         hold_done  <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_stall <= (hold_cnt > 1);
      end else if (!hold_done && rsp_seen >= 150) begin
         hold_done <= 1'b1;
         hold_cnt  <= HOLD_LEN;
         rsp_stall <= 1'b1;
      end else begin
         mode_cnt <= mode_cnt + 1;
         if (mode_cnt % 64 == 63) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 0);
            2: rsp_stall <= ($urandom_range(0, 7) != 0);
            default: rsp_stall <= (mode_cnt % 5 < 2);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // monitor: compare each taken response with the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen <= rsp_seen + 1;
         if (expected_rsp.size() == 0) begin
            $error("response with nothing outstanding: moved_amount %0d status %0d",
                   rsp_moved_amount, rsp_status);
            errors <= errors + 1;
         end else begin
            rsp_word_type e;
            e = expected_rsp.pop_front();
            if (rsp_moved_amount !== e.moved) begin
               $error("moved_amount: expected %0d actual %0d", e.moved, rsp_moved_amount);
               errors <= errors + 1;
            end
            if (rsp_status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_status);
               errors <= errors + 1;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("capacity_limited_slot_store regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [FIX_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_MASS_LIMIT:   shadow_mass_limit   = data;
         CSR_VOLUME_LIMIT: shadow_volume_limit = data;
         CSR_SLOTS_IN_USE: shadow_slots        = data[4:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [FIX_W-1:0] ml, logic [FIX_W-1:0] vl,
                            logic [FIX_W-1:0] slots);
      csr_write(CSR_MASS_LIMIT, ml);
      csr_write(CSR_VOLUME_LIMIT, vl);
      csr_write(CSR_SLOTS_IN_USE, slots);
   endtask

   // block until every word went out and every response came back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0);
   endtask

   task automatic push_word(logic cmd, logic [KEY_W-1:0] key, logic [AMOUNT_W-1:0] amt,
                            logic [FIX_W-1:0] um, logic [FIX_W-1:0] uv);
      req_word_type w;
      w.cmd = cmd; w.key = key; w.amount = amt;
      w.mass_each = um; w.volume_each = uv;
      pending_words.push_back(w);
   endtask

   function automatic logic [FIX_W-1:0] pick_cost();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 32'h0004_0000);
      if (r < 68) return '0;
      if (r < 78) return -$urandom_range(1, 32'h0010_0000);
      if (r < 90) return $urandom;
      if (r < 95) return 32'h7FFF_FFFF;
      return 32'h8000_0000;
   endfunction

   function automatic logic [FIX_W-1:0] pick_limit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(1, 2000) << 16;
      if (r < 62) return 32'h7FFF_FFFF;
      if (r < 72) return 32'h8000_0000;
      if (r < 82) return '0;
      return $urandom;
   endfunction

   function automatic logic [FIX_W-1:0] pick_slots();
      int r;
      r = $urandom_range(0, 7);
      case (r)
         0: return 0;
         1: return 1;
         2: return 3;
         3: return 16;
         4: return 17;
         5: return 31;
         default: return $urandom;  // low 5 bits land anywhere in 0..31
      endcase
   endfunction

   // mostly pack/unpack traffic on a small key pool so slots fill and drain,
   // with some invalid, foreign and extreme words mixed in
   task automatic push_random_word();
      int               r;
      logic [KEY_W-1:0] key;
      logic [AMOUNT_W-1:0] amt;
      r = $urandom_range(0, 99);
      if (r < 85)      key = $urandom_range(1, 6);
      else if (r < 90) key = '0;
      else if (r < 96) key = $urandom;
      else             key = 32'hFFFF_FFFF;
      r = $urandom_range(0, 99);
      if (r < 70)      amt = AMOUNT_W'($urandom_range(1, 40));
      else if (r < 75) amt = '0;
      else if (r < 90) amt = AMOUNT_W'($urandom);
      else             amt = 31'h7FFF_FFFF;
      push_word(($urandom_range(0, 99) < 55) ? CMD_PACK : CMD_UNPACK,
                key, amt, pick_cost(), pick_cost());
   endtask

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wr_data = '0;
      no_gaps     = 1'b0;
      shadow_mass_limit  = '0;
      shadow_volume_limit = '0;
      shadow_slots       = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: two slots, unbounded capacity
      configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 2);
      push_word(CMD_PACK,   '0, 5, 32'h0001_0000, 32'h0001_0000);  // invalid key
      push_word(CMD_PACK,   1, 0, 32'h0001_0000, 32'h0001_0000);   // zero amount
      push_word(CMD_PACK,   1, 10, 32'h0001_0000, 32'h0001_0000);
      push_word(CMD_PACK,   2, 5, 32'h0002_0000, 32'h0000_8000);
      push_word(CMD_PACK,   3, 4, 32'h0001_0000, 32'h0001_0000);   // no free slot
      push_word(CMD_UNPACK, 7, 4, 32'h0001_0000, 32'h0001_0000);   // key not held
      push_word(CMD_UNPACK, 1, 31'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000);
      push_word(CMD_PACK,   3, 31'h7FFF_FFFF, '0, 32'hFFFF_FFFF); // no bound at all
      push_word(CMD_PACK,   2, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
      push_word(CMD_UNPACK, 3, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      push_word(CMD_UNPACK, 32'hFFFF_FFFF, 1, 32'h0001_0000, 32'h0001_0000);
      wait_drained();

      // directed: bulk mode with a tight mass limit
      configure(100 << 16, 32'h7FFF_FFFF, 0);
      push_word(CMD_UNPACK, 2, 31'h7FFF_FFFF, '0, '0);
      push_word(CMD_PACK,   4, 50, 3 << 16, 1 << 16);
      push_word(CMD_PACK,   5, 3, 1 << 16, 1 << 16);                // other key held
      push_word(CMD_UNPACK, 4, 1, 32'h8000_0000, 1 << 16);
      push_word(CMD_UNPACK, 4, 31'h7FFF_FFFF, 3 << 16, 1 << 16);
      push_word(CMD_PACK,   5, 3, 1 << 16, 1 << 16);
      wait_drained();

      // directed: slot count above the table size, negative limit
      configure(32'h8000_0000, '0, 31);
      push_word(CMD_PACK,   9, 3, 1 << 16, 1 << 16);                // no room
      push_word(CMD_PACK,   9, 3, 32'h8000_0000, 32'hFFFF_0000);
      push_word(CMD_UNPACK, 9, 2, 32'h8000_0000, 32'h7FFF_FFFF);
      push_word(CMD_UNPACK, 5, 31'h7FFF_FFFF, 1 << 16, 1 << 16);
      wait_drained();

      // random phases; the sender pauses at each boundary until drained
      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 1)      configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16);
         else if (ph == 2) configure(32'hFFFF_FFFF, 32'h0000_0000, 5'h1F);
         else              configure(pick_limit(), pick_limit(), pick_slots());
         no_gaps = (ph % 4 == 3);
         for (int k = 0; k < 53; k++) push_random_word();
         wait_drained();
      end
      no_gaps = 1'b0;

      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("capacity_limited_slot_store regression: pass");
      end else begin
         $display("capacity_limited_slot_store regression: fail");
      end
      $finish;
   end

endmodule
